>>> sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds screen geometry, request and control-character codes, and the cell address helper.
// Depends on nothing; used by text_console_writer.
`timescale 1ns / 1ps

package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    // Cells that move during a scroll: every row but the top one.
    localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    // Field widths.
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_TEXT_ATTR = 1'b0;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;

    // Stream payload widths.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_SETCUR = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // A tab puts this many spaces.
    localparam int TAB_SPACES = 8;
    localparam int TAB_W = $clog2(TAB_SPACES + 1);

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(COLUMNS);
        return base + ADDR_W'(col);
    endfunction

endpackage

>>> sv/text_console_writer.sv
// Text console writer top level: screen memory, cursor, request sequencer and APB register.
// Depends on tcw_pkg for geometry, codes and the cell address helper.
`timescale 1ns / 1ps

// The block owns a ROWS x COLUMNS screen of 16-bit cells (attribute in the high byte,
// character in the low byte) held in a single-port-write, single-port-read memory, and
// a cursor. Requests arrive one at a time on the slave stream; each gives exactly one
// result item on the master stream carrying the cursor after the request and, for a
// read, the cell. With one memory write per cycle, a plain character writes one cell,
// a tab writes TAB_SPACES spaces, a newline that does not scroll, a return, a backspace,
// a set cursor or a read writes none, each scroll moves the rows below the top up and
// blanks the bottom row, and a clear screen writes every cell.
// After reset the memory is cleared in a pass during which no item is accepted; the
// attribute register can be written at any time.
// A result waiting on the master side does not hold off the next accept.
module text_console_writer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    // Request stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // char_code [7:0], row [12:8], col [19:13], zero fill [23:20]
    input  logic [tcw_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type [1:0]
    input  logic [tcw_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // Result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // cur_row [4:0], cur_col [11:5], cell_value [27:12], zero fill [31:28]
    output logic [tcw_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_GLYPH  = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_READ   = 6'b010000,
        ST_RESP   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [tcw_pkg::ROW_W-1:0]  r_row, n_row;
    logic [tcw_pkg::COL_W-1:0]  r_col, n_col;
    logic [tcw_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [tcw_pkg::TAB_W-1:0]  r_tab, n_tab;
    logic [tcw_pkg::CHAR_W-1:0] r_char, n_char;
    logic [tcw_pkg::CELL_W-1:0] r_cell, n_cell;
    logic                       r_post, n_post;
    logic [tcw_pkg::ATTR_W-1:0] r_attr;

    logic                       r_out_valid;
    logic [tcw_pkg::ROW_W-1:0]  r_out_row;
    logic [tcw_pkg::COL_W-1:0]  r_out_col;
    logic [tcw_pkg::CELL_W-1:0] r_out_cell;

    // Screen memory
    logic [tcw_pkg::CELL_W-1:0] r_screen [tcw_pkg::CELLS];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;
    logic                       w_we;
    logic [tcw_pkg::ADDR_W-1:0] w_waddr;
    logic [tcw_pkg::CELL_W-1:0] w_wdata;
    logic [tcw_pkg::ADDR_W-1:0] w_raddr;

    // Request fields
    logic                       w_accept;
    tcw_pkg::t_req              w_req;
    logic [tcw_pkg::CHAR_W-1:0] w_in_char;
    logic [tcw_pkg::ROW_W-1:0]  w_in_row, w_sat_row;
    logic [tcw_pkg::COL_W-1:0]  w_in_col, w_sat_col;
    logic [tcw_pkg::ADDR_W-1:0] w_in_addr;

    // Scroll source and destination counters
    logic [tcw_pkg::CNT_W-1:0]  w_scr_src;
    logic [tcw_pkg::CNT_W-1:0]  w_scr_dst;

    logic                       w_apb_wr;

    assign w_req     = tcw_pkg::t_req'(s_axis_tuser[1:0]);
    assign w_in_char = s_axis_tdata[7:0];
    assign w_in_row  = s_axis_tdata[12:8];
    assign w_in_col  = s_axis_tdata[19:13];
    assign w_sat_row = (w_in_row > tcw_pkg::ROW_LAST) ? tcw_pkg::ROW_LAST : w_in_row;
    assign w_sat_col = (w_in_col > tcw_pkg::COL_LAST) ? tcw_pkg::COL_LAST : w_in_col;
    assign w_in_addr = tcw_pkg::cell_addr(w_sat_row, w_sat_col);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_scr_src = r_cnt + tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
    assign w_scr_dst = r_cnt - tcw_pkg::CNT_W'(1);

    // APB register
    assign pready   = 1'b1;
    assign w_apb_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == tcw_pkg::REG_TEXT_ATTR) ?
                      {{(tcw_pkg::PDATA_W - tcw_pkg::ATTR_W){1'b0}}, r_attr} :
                      '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (w_apb_wr && (paddr[2] == tcw_pkg::REG_TEXT_ATTR)) begin
            r_attr <= pwdata[tcw_pkg::ATTR_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_cnt   = r_cnt;
        n_tab   = r_tab;
        n_char  = r_char;
        n_cell  = r_cell;
        n_post  = r_post;
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_raddr = w_in_addr;

        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt[tcw_pkg::ADDR_W-1:0];
                if (r_cnt == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = r_post ? ST_RESP : ST_IDLE;
                end else begin
                    n_cnt = r_cnt + tcw_pkg::CNT_W'(1);
                end
            end

            ST_IDLE: begin
                if (w_accept) begin
                    n_cell = '0;
                    n_tab  = '0;
                    n_cnt  = '0;
                    unique case (w_req)
                        tcw_pkg::REQ_PUT: begin
                            case (w_in_char)
                                tcw_pkg::CH_NEWLINE: begin
                                    n_col = '0;
                                    if (r_row == tcw_pkg::ROW_LAST) begin
                                        n_state = ST_SCROLL;
                                    end else begin
                                        n_row   = r_row + tcw_pkg::ROW_W'(1);
                                        n_state = ST_RESP;
                                    end
                                end
                                tcw_pkg::CH_RETURN: begin
                                    n_col   = '0;
                                    n_state = ST_RESP;
                                end
                                tcw_pkg::CH_TAB: begin
                                    n_char  = tcw_pkg::CH_SPACE;
                                    n_tab   = tcw_pkg::TAB_W'(tcw_pkg::TAB_SPACES);
                                    n_state = ST_GLYPH;
                                end
                                tcw_pkg::CH_BACKSPACE: begin
                                    if (r_col != '0) begin
                                        n_col = r_col - tcw_pkg::COL_W'(1);
                                    end
                                    n_state = ST_RESP;
                                end
                                default: begin
                                    n_char  = w_in_char;
                                    n_tab   = tcw_pkg::TAB_W'(1);
                                    n_state = ST_GLYPH;
                                end
                            endcase
                        end
                        tcw_pkg::REQ_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_post  = 1'b1;
                            n_state = ST_CLEAR;
                        end
                        tcw_pkg::REQ_SETCUR: begin
                            n_row   = w_sat_row;
                            n_col   = w_sat_col;
                            n_state = ST_RESP;
                        end
                        tcw_pkg::REQ_READ: begin
                            n_state = ST_READ;
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end

            ST_GLYPH: begin
                // r_tab counts the glyphs still to write, this one included.
                w_we    = 1'b1;
                w_waddr = tcw_pkg::cell_addr(r_row, r_col);
                w_wdata = {r_attr, r_char};
                n_tab   = r_tab - tcw_pkg::TAB_W'(1);
                n_state = (r_tab == tcw_pkg::TAB_W'(1)) ? ST_RESP : ST_GLYPH;
                if (r_col == tcw_pkg::COL_LAST) begin
                    n_col = '0;
                    if (r_row == tcw_pkg::ROW_LAST) begin
                        n_cnt   = '0;
                        n_state = ST_SCROLL;
                    end else begin
                        n_row = r_row + tcw_pkg::ROW_W'(1);
                    end
                end else begin
                    n_col = r_col + tcw_pkg::COL_W'(1);
                end
            end

            ST_SCROLL: begin
                // Read one row below while writing the cell read in the previous cycle; the
                // bottom row gets zeros once the moved cells run out.
                if (r_cnt < tcw_pkg::CNT_W'(tcw_pkg::SCROLL_CELLS)) begin
                    w_raddr = w_scr_src[tcw_pkg::ADDR_W-1:0];
                end else begin
                    w_raddr = '0;
                end
                if (r_cnt != '0) begin
                    w_we    = 1'b1;
                    w_waddr = w_scr_dst[tcw_pkg::ADDR_W-1:0];
                    w_wdata = (r_cnt <= tcw_pkg::CNT_W'(tcw_pkg::SCROLL_CELLS)) ? r_rdata : '0;
                end
                if (r_cnt == tcw_pkg::CNT_W'(tcw_pkg::CELLS)) begin
                    n_cnt   = '0;
                    n_state = (r_tab != '0) ? ST_GLYPH : ST_RESP;
                end else begin
                    n_cnt = r_cnt + tcw_pkg::CNT_W'(1);
                end
            end

            ST_READ: begin
                n_cell  = r_rdata;
                n_state = ST_RESP;
            end

            ST_RESP: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_row   <= '0;
            r_col   <= '0;
            r_cnt   <= '0;
            r_tab   <= '0;
            r_post  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_cnt   <= n_cnt;
            r_tab   <= n_tab;
            r_post  <= n_post;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_cell <= n_cell;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_screen[w_waddr] <= w_wdata;
        end
        r_rdata <= r_screen[w_raddr];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_RESP && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESP && (!r_out_valid || m_axis_tready)) begin
            r_out_row  <= r_row;
            r_out_col  <= r_col;
            r_out_cell <= r_cell;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_cell, r_out_col, r_out_row};

    // The cursor never leaves the screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= tcw_pkg::ROW_LAST) && (r_col <= tcw_pkg::COL_LAST))
        else $error("cursor outside the screen");

    // An accepted item always starts work before another can be taken.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("accepted item left the sequencer idle");

    // The screen is never written while waiting for a request.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_RESP) |-> !w_we)
        else $error("screen written outside a request");

    // A finished result waits while the output register is full and stalled.
    a_resp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP && r_out_valid && !m_axis_tready) |=> (r_state == ST_RESP))
        else $error("result dropped while output stalled");

endmodule
